>>> rtl/core/hcd_pkg.sv
package hcd_pkg;

    localparam int FRAC_BITS    = 20;
    localparam int BISECT_STEPS = 4;
    localparam int A_W          = BISECT_STEPS + 1;
    localparam int DW           = 104;
    localparam int CH_W         = 26;
    localparam int RF_N         = 27;
    localparam int PC_W         = 6;
    localparam int K_W          = 4;
    localparam int BW           = BISECT_STEPS + 36;

    localparam logic [A_W-1:0] A_FULL = A_W'(1 << BISECT_STEPS);
    localparam logic [A_W-1:0] A_HALF = A_W'(1 << (BISECT_STEPS - 1));

    typedef struct packed {
        logic signed [31:0] h00;
        logic signed [31:0] h01;
        logic signed [31:0] h02;
        logic signed [31:0] h10;
        logic signed [31:0] h11;
        logic signed [31:0] h12;
        logic signed [31:0] h20;
        logic signed [31:0] h21;
        logic signed [31:0] h22;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_00;
        logic signed [31:0] out_01;
        logic signed [31:0] out_02;
        logic signed [31:0] out_10;
        logic signed [31:0] out_11;
        logic signed [31:0] out_12;
        logic signed [31:0] out_20;
        logic signed [31:0] out_21;
        logic signed [31:0] out_22;
        logic               was_modified;
    } t_out;

    typedef enum logic [3:0] {
        OP_BLD,
        OP_LOOP,
        OP_CLRF,
        OP_CLR,
        OP_LDM,
        OP_MAC,
        OP_ADD,
        OP_ST,
        OP_CHKZ,
        OP_TST,
        OP_END
    } t_op;

    typedef logic [5:0]      t_adr;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_adr AD_M0  = 6'd0;
    localparam t_adr AD_M1  = 6'd1;
    localparam t_adr AD_M2  = 6'd2;
    localparam t_adr AD_A0  = 6'd9;
    localparam t_adr AD_A1  = 6'd10;
    localparam t_adr AD_A2  = 6'd11;
    localparam t_adr AD_A3  = 6'd12;
    localparam t_adr AD_A4  = 6'd13;
    localparam t_adr AD_A5  = 6'd14;
    localparam t_adr AD_A6  = 6'd15;
    localparam t_adr AD_A7  = 6'd16;
    localparam t_adr AD_A8  = 6'd17;
    localparam t_adr AD_CX0 = 6'd18;
    localparam t_adr AD_CX1 = 6'd19;
    localparam t_adr AD_CY0 = 6'd20;
    localparam t_adr AD_CY1 = 6'd21;
    localparam t_adr AD_W   = 6'd22;
    localparam t_adr AD_HH  = 6'd23;
    localparam t_adr AD_NX  = 6'd24;
    localparam t_adr AD_NY  = 6'd25;
    localparam t_adr AD_D   = 6'd26;
    localparam t_adr AD_IP  = 6'd32;
    localparam t_adr AD_IQ  = 6'd33;
    localparam t_adr AD_IR  = 6'd34;
    localparam t_adr AD_IS  = 6'd35;
    localparam t_adr AD_IA  = 6'd36;
    localparam t_adr AD_ICX = 6'd37;
    localparam t_adr AD_ICY = 6'd38;

    localparam t_pc P_BLEND = 6'd0;
    localparam t_pc P_TEST  = 6'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;

    typedef struct packed {
        t_op            op;
        t_adr           ad;
        logic           sub;
        logic [K_W-1:0] lim;
        t_pc            tgt;
    } t_uword;

    typedef struct packed {
        logic           load;
        logic           run;
        t_uword         uw;
        logic [K_W-1:0] k;
        logic [A_W-1:0] a;
    } t_ctl;

    typedef struct packed {
        logic mac_done;
        logic pass;
    } t_sts;

endpackage

>>> rtl/core/hcd_ucode_rom.sv
module hcd_ucode_rom (
    input  hcd_pkg::t_pc    i_pc,
    output hcd_pkg::t_uword o_uw
);

    function automatic hcd_pkg::t_uword mk(input hcd_pkg::t_op op, input hcd_pkg::t_adr ad,
                                           input logic sub, input logic [hcd_pkg::K_W-1:0] lim,
                                           input hcd_pkg::t_pc tgt);
        hcd_pkg::t_uword w;
        w.op  = op;
        w.ad  = ad;
        w.sub = sub;
        w.lim = lim;
        w.tgt = tgt;
        return w;
    endfunction

    function automatic hcd_pkg::t_uword op1(input hcd_pkg::t_op op, input hcd_pkg::t_adr ad);
        return mk(op, ad, 1'b0, '0, hcd_pkg::P_BLEND);
    endfunction

    always_comb begin
        case (i_pc)
            6'd0:  o_uw = op1(hcd_pkg::OP_BLD, hcd_pkg::AD_M0);
            6'd1:  o_uw = mk(hcd_pkg::OP_LOOP, hcd_pkg::AD_M0, 1'b0, 4'd9, hcd_pkg::P_BLEND);
            6'd2:  o_uw = op1(hcd_pkg::OP_CLRF, hcd_pkg::AD_M0);
            6'd3:  o_uw = op1(hcd_pkg::OP_CLR, hcd_pkg::AD_M0);
            6'd4:  o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_IP);
            6'd5:  o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_IQ);
            6'd6:  o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_IR);
            6'd7:  o_uw = mk(hcd_pkg::OP_MAC, hcd_pkg::AD_IS, 1'b1, '0, hcd_pkg::P_BLEND);
            6'd8:  o_uw = op1(hcd_pkg::OP_ST, hcd_pkg::AD_IA);
            6'd9:  o_uw = mk(hcd_pkg::OP_LOOP, hcd_pkg::AD_M0, 1'b0, 4'd9, 6'd3);
            6'd10: o_uw = op1(hcd_pkg::OP_CLR, hcd_pkg::AD_M0);
            6'd11: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A0);
            6'd12: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_M0);
            6'd13: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A3);
            6'd14: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_M1);
            6'd15: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A6);
            6'd16: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_M2);
            6'd17: o_uw = op1(hcd_pkg::OP_CHKZ, hcd_pkg::AD_M0);
            6'd18: o_uw = op1(hcd_pkg::OP_CLR, hcd_pkg::AD_M0);
            6'd19: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A0);
            6'd20: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_ICX);
            6'd21: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A1);
            6'd22: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_ICY);
            6'd23: o_uw = op1(hcd_pkg::OP_ADD, hcd_pkg::AD_A2);
            6'd24: o_uw = op1(hcd_pkg::OP_ST, hcd_pkg::AD_NX);
            6'd25: o_uw = op1(hcd_pkg::OP_CLR, hcd_pkg::AD_M0);
            6'd26: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A3);
            6'd27: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_ICX);
            6'd28: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A4);
            6'd29: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_ICY);
            6'd30: o_uw = op1(hcd_pkg::OP_ADD, hcd_pkg::AD_A5);
            6'd31: o_uw = op1(hcd_pkg::OP_ST, hcd_pkg::AD_NY);
            6'd32: o_uw = op1(hcd_pkg::OP_CLR, hcd_pkg::AD_M0);
            6'd33: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A6);
            6'd34: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_ICX);
            6'd35: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_A7);
            6'd36: o_uw = op1(hcd_pkg::OP_MAC, hcd_pkg::AD_ICY);
            6'd37: o_uw = op1(hcd_pkg::OP_ADD, hcd_pkg::AD_A8);
            6'd38: o_uw = op1(hcd_pkg::OP_ST, hcd_pkg::AD_D);
            6'd39: o_uw = op1(hcd_pkg::OP_CLR, hcd_pkg::AD_M0);
            6'd40: o_uw = op1(hcd_pkg::OP_ADD, hcd_pkg::AD_NX);
            6'd41: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_D);
            6'd42: o_uw = mk(hcd_pkg::OP_MAC, hcd_pkg::AD_W, 1'b1, '0, hcd_pkg::P_BLEND);
            6'd43: o_uw = op1(hcd_pkg::OP_TST, hcd_pkg::AD_NX);
            6'd44: o_uw = op1(hcd_pkg::OP_CLR, hcd_pkg::AD_M0);
            6'd45: o_uw = op1(hcd_pkg::OP_ADD, hcd_pkg::AD_NY);
            6'd46: o_uw = op1(hcd_pkg::OP_LDM, hcd_pkg::AD_D);
            6'd47: o_uw = mk(hcd_pkg::OP_MAC, hcd_pkg::AD_HH, 1'b1, '0, hcd_pkg::P_BLEND);
            6'd48: o_uw = op1(hcd_pkg::OP_TST, hcd_pkg::AD_NY);
            6'd49: o_uw = mk(hcd_pkg::OP_LOOP, hcd_pkg::AD_M0, 1'b0, 4'd4, 6'd18);
            default: o_uw = op1(hcd_pkg::OP_END, hcd_pkg::AD_M0);
        endcase
    end

endmodule

>>> rtl/core/hcd_datapath.sv
module hcd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcd_pkg::t_ctl     i_ctl,
    input  hcd_pkg::t_in      i_h,
    input  logic [13:0]       i_width,
    input  logic [13:0]       i_height,
    input  logic [16:0]       i_scale,
    output hcd_pkg::t_sts     o_sts,
    output logic [8:0][31:0]  o_mat
);

    localparam int DW   = hcd_pkg::DW;
    localparam int CH_W = hcd_pkg::CH_W;
    localparam int BW   = hcd_pkg::BW;

    logic signed [DW-1:0]   r_rf [0:hcd_pkg::RF_N-1];
    logic signed [31:0]     r_h  [0:8];
    logic signed [DW-1:0]   r_acc;
    logic signed [DW-1:0]   r_mc;
    logic        [DW-1:0]   r_ma;
    logic        [DW-1:0]   r_p;
    logic        [31:0]     r_mb;
    logic        [CH_W+31:0] r_pp;
    logic                   r_neg;
    logic                   r_busy;
    logic        [2:0]      r_cnt;
    logic                   r_pass;

    logic signed [31:0]     h_arr [0:8];
    logic        [16:0]     sc;
    logic        [16:0]     marg;
    logic        [30:0]     wprod;
    logic        [30:0]     hprod;
    logic        [13:0]     wm;
    logic        [13:0]     hm;
    logic        [15:0]     sel;
    logic        [4:0]      ra;
    logic signed [DW-1:0]   rd;
    logic signed [DW-1:0]   dd;
    logic        [DW-1:0]   mag_a;
    logic        [31:0]     mag_b;
    logic        [CH_W-1:0] chunk;
    logic        [DW-1:0]   pp_sh;
    logic                   tst_ok;
    logic signed [31:0]     hk;
    logic                   diag;
    logic signed [BW-1:0]   av;
    logic signed [BW-1:0]   hv;
    logic signed [BW-1:0]   dv;
    logic signed [BW-1:0]   bv;
    logic signed [BW-1:0]   bq;
    logic signed [31:0]     bsat;

    function automatic logic [15:0] cof_sel(input logic [hcd_pkg::K_W-1:0] k);
        case (k)
            4'd0:    return 16'h4857;
            4'd1:    return 16'h2718;
            4'd2:    return 16'h1524;
            4'd3:    return 16'h5638;
            4'd4:    return 16'h0826;
            4'd5:    return 16'h2305;
            4'd6:    return 16'h3746;
            4'd7:    return 16'h1607;
            4'd8:    return 16'h0413;
            default: return 16'h0000;
        endcase
    endfunction

    always_comb begin
        h_arr[0] = i_h.h00;
        h_arr[1] = i_h.h01;
        h_arr[2] = i_h.h02;
        h_arr[3] = i_h.h10;
        h_arr[4] = i_h.h11;
        h_arr[5] = i_h.h12;
        h_arr[6] = i_h.h20;
        h_arr[7] = i_h.h21;
        h_arr[8] = i_h.h22;
    end

    assign sc    = (i_scale > 17'd65536) ? 17'd65536 : i_scale;
    assign marg  = 17'd65536 - sc;
    assign wprod = 31'(i_width) * 31'(marg);
    assign hprod = 31'(i_height) * 31'(marg);
    assign wm    = wprod[30:17];
    assign hm    = hprod[30:17];

    always_comb begin
        sel = cof_sel(i_ctl.k);
        unique case (i_ctl.uw.ad)
            hcd_pkg::AD_IP:  ra = {1'b0, sel[15:12]};
            hcd_pkg::AD_IQ:  ra = {1'b0, sel[11:8]};
            hcd_pkg::AD_IR:  ra = {1'b0, sel[7:4]};
            hcd_pkg::AD_IS:  ra = {1'b0, sel[3:0]};
            hcd_pkg::AD_IA:  ra = hcd_pkg::AD_A0[4:0] + {1'b0, i_ctl.k};
            hcd_pkg::AD_ICX: ra = (i_ctl.k == 4'd1 || i_ctl.k == 4'd2) ?
                                  hcd_pkg::AD_CX1[4:0] : hcd_pkg::AD_CX0[4:0];
            hcd_pkg::AD_ICY: ra = (i_ctl.k >= 4'd2) ?
                                  hcd_pkg::AD_CY1[4:0] : hcd_pkg::AD_CY0[4:0];
            default:         ra = i_ctl.uw.ad[4:0];
        endcase
    end

    assign rd    = r_rf[ra];
    assign dd    = r_rf[hcd_pkg::AD_D[4:0]];
    assign mag_a = r_mc[DW-1] ? DW'(-r_mc) : DW'(r_mc);
    assign mag_b = rd[31] ? 32'(-rd[31:0]) : rd[31:0];

    always_comb begin
        case (r_cnt[1:0])
            2'd0:    chunk = r_ma[CH_W*0 +: CH_W];
            2'd1:    chunk = r_ma[CH_W*1 +: CH_W];
            2'd2:    chunk = r_ma[CH_W*2 +: CH_W];
            default: chunk = r_ma[CH_W*3 +: CH_W];
        endcase
        case (r_cnt[1:0] - 2'd1)
            2'd0:    pp_sh = DW'(r_pp);
            2'd1:    pp_sh = DW'(r_pp) << CH_W;
            2'd2:    pp_sh = DW'(r_pp) << (CH_W * 2);
            default: pp_sh = DW'(r_pp) << (CH_W * 3);
        endcase
    end

    assign tst_ok = ((dd > 0) && (rd >= 0) && (r_acc < 0)) ||
                    ((dd < 0) && (rd <= 0) && (r_acc > 0));

    assign hk   = r_h[i_ctl.k];
    assign diag = (i_ctl.k == 4'd0) || (i_ctl.k == 4'd4) || (i_ctl.k == 4'd8);

    always_comb begin
        av = BW'(i_ctl.a);
        hv = BW'(hk);
        dv = diag ? (BW'(hcd_pkg::A_FULL - i_ctl.a) << hcd_pkg::FRAC_BITS) : '0;
        bv = av * hv + dv + BW'(hcd_pkg::A_HALF);
        bq = bv >>> hcd_pkg::BISECT_STEPS;
        if (bq > BW'(32'sh7fffffff)) begin
            bsat = 32'sh7fffffff;
        end else if (bq < -(BW'(33'sh080000000))) begin
            bsat = 32'sh80000000;
        end else begin
            bsat = bq[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_pass <= 1'b0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_pass <= 1'b1;
        end else if (i_ctl.run) begin
            unique case (i_ctl.uw.op)
                hcd_pkg::OP_CLRF: r_pass <= 1'b1;
                hcd_pkg::OP_CHKZ: if (r_acc == 0) r_pass <= 1'b0;
                hcd_pkg::OP_TST:  if (!tst_ok) r_pass <= 1'b0;
                hcd_pkg::OP_MAC: begin
                    if (!r_busy) begin
                        r_busy <= 1'b1;
                        r_cnt  <= '0;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                        if (r_cnt == 3'd5) r_busy <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            for (int i = 0; i < 9; i++) begin
                r_rf[i] <= DW'(h_arr[i]);
                r_h[i]  <= h_arr[i];
            end
            r_rf[hcd_pkg::AD_CX0[4:0]] <= DW'(wm);
            r_rf[hcd_pkg::AD_CX1[4:0]] <= DW'(i_width - wm);
            r_rf[hcd_pkg::AD_CY0[4:0]] <= DW'(hm);
            r_rf[hcd_pkg::AD_CY1[4:0]] <= DW'(i_height - hm);
            r_rf[hcd_pkg::AD_W[4:0]]   <= DW'(i_width);
            r_rf[hcd_pkg::AD_HH[4:0]]  <= DW'(i_height);
        end else if (i_ctl.run) begin
            unique case (i_ctl.uw.op)
                hcd_pkg::OP_BLD: r_rf[{1'b0, i_ctl.k}] <= DW'(bsat);
                hcd_pkg::OP_CLR: r_acc <= '0;
                hcd_pkg::OP_LDM: r_mc <= rd;
                hcd_pkg::OP_ADD: r_acc <= r_acc + rd;
                hcd_pkg::OP_ST:  r_rf[ra] <= r_acc;
                hcd_pkg::OP_MAC: begin
                    if (!r_busy) begin
                        r_ma  <= mag_a;
                        r_mb  <= mag_b;
                        r_neg <= r_mc[DW-1] ^ rd[31] ^ i_ctl.uw.sub;
                        r_p   <= '0;
                    end else begin
                        if (r_cnt <= 3'd3) r_pp <= (CH_W+32)'(chunk) * (CH_W+32)'(r_mb);
                        if (r_cnt >= 3'd1 && r_cnt <= 3'd4) r_p <= r_p + pp_sh;
                        if (r_cnt == 3'd5) begin
                            r_acc <= r_neg ? (r_acc - $signed(r_p)) : (r_acc + $signed(r_p));
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_sts.mac_done = i_ctl.run && (i_ctl.uw.op == hcd_pkg::OP_MAC) && r_busy &&
                            (r_cnt == 3'd5);
    assign o_sts.pass     = r_pass;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            o_mat[i] = r_rf[i][31:0];
        end
    end

endmodule

>>> rtl/core/homography_crop_damping.sv
// A result follows the first test when all four crop corners
// land inside; otherwise the four damping steps run first.
// Input is accepted only in idle, so one matrix is handled at a time, and a run ends
// only once the output is free; each test is a microcode pass, mostly on the shared
// 26x32 chunked multiplier (53 products), and each damping step adds a blend.
// Reset: synchronous active-low; registers return to 1920, 1080, 58982, no beat pending.
module homography_crop_damping (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  hcd_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output hcd_pkg::t_out   o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [16:0]     i_cfg_data
);

    localparam int A_W = hcd_pkg::A_W;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                   r_state;
    hcd_pkg::t_pc             r_pc;
    logic [hcd_pkg::K_W-1:0]  r_k;
    logic                     r_bis;
    logic [A_W-1:0]           r_lo;
    logic [A_W-1:0]           r_hi;
    logic [A_W-1:0]           r_a;
    logic [A_W-1:0]           r_iter;
    logic                     r_ovalid;
    hcd_pkg::t_out            r_out;
    logic [13:0]              r_width;
    logic [13:0]              r_height;
    logic [16:0]              r_scale;

    hcd_pkg::t_uword          uw;
    hcd_pkg::t_ctl            ctl;
    hcd_pkg::t_sts            sts;
    logic [8:0][31:0]         mat;
    logic                     in_acc;
    logic                     out_free;
    logic                     out_take;
    logic [A_W-1:0]           n_lo;
    logic [A_W-1:0]           n_hi;
    logic [A_W:0]             n_sum;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign out_take    = (r_state == ST_RUN) && (uw.op == hcd_pkg::OP_END) && out_free &&
                         (r_bis ? (r_iter == A_W'(hcd_pkg::BISECT_STEPS - 1)) : sts.pass);

    hcd_ucode_rom u_rom (
        .i_pc (r_pc),
        .o_uw (uw)
    );

    always_comb begin
        ctl.load = in_acc;
        ctl.run  = (r_state == ST_RUN);
        ctl.uw   = uw;
        ctl.k    = r_k;
        ctl.a    = r_a;
    end

    hcd_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_h      (i_in_data),
        .i_width  (r_width),
        .i_height (r_height),
        .i_scale  (r_scale),
        .o_sts    (sts),
        .o_mat    (mat)
    );

    assign n_lo  = sts.pass ? r_a : r_lo;
    assign n_hi  = sts.pass ? r_hi : r_a;
    assign n_sum = {1'b0, n_lo} + {1'b0, n_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pc     <= hcd_pkg::P_TEST;
            r_k      <= '0;
            r_bis    <= 1'b0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_a      <= '0;
            r_iter   <= '0;
            r_ovalid <= 1'b0;
            r_width  <= 14'd1920;
            r_height <= 14'd1080;
            r_scale  <= 17'd58982;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    hcd_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[13:0];
                    hcd_pkg::CFG_HEIGHT: r_height <= i_cfg_data[13:0];
                    hcd_pkg::CFG_SCALE:  r_scale  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_out_ready && !out_take) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_RUN;
                        r_pc    <= hcd_pkg::P_TEST;
                        r_k     <= '0;
                        r_bis   <= 1'b0;
                    end
                end
                ST_RUN: begin
                    unique case (uw.op)
                        hcd_pkg::OP_MAC: begin
                            if (sts.mac_done) r_pc <= r_pc + 6'd1;
                        end
                        hcd_pkg::OP_LOOP: begin
                            if (r_k + 4'd1 < uw.lim) begin
                                r_k  <= r_k + 4'd1;
                                r_pc <= uw.tgt;
                            end else begin
                                r_k  <= '0;
                                r_pc <= r_pc + 6'd1;
                            end
                        end
                        hcd_pkg::OP_END: begin
                            if (!r_bis && !sts.pass) begin
                                r_bis  <= 1'b1;
                                r_lo   <= '0;
                                r_hi   <= hcd_pkg::A_FULL;
                                r_a    <= hcd_pkg::A_HALF;
                                r_iter <= '0;
                                r_pc   <= hcd_pkg::P_BLEND;
                            end else if (r_bis &&
                                         r_iter != A_W'(hcd_pkg::BISECT_STEPS - 1)) begin
                                r_lo   <= n_lo;
                                r_hi   <= n_hi;
                                r_a    <= n_sum[A_W:1];
                                r_iter <= r_iter + A_W'(1);
                                r_pc   <= hcd_pkg::P_BLEND;
                            end else if (out_free) begin
                                r_ovalid           <= 1'b1;
                                r_out.out_00       <= mat[0];
                                r_out.out_01       <= mat[1];
                                r_out.out_02       <= mat[2];
                                r_out.out_10       <= mat[3];
                                r_out.out_11       <= mat[4];
                                r_out.out_12       <= mat[5];
                                r_out.out_20       <= mat[6];
                                r_out.out_21       <= mat[7];
                                r_out.out_22       <= mat[8];
                                r_out.was_modified <= r_bis;
                                r_bis              <= 1'b0;
                                r_state            <= ST_IDLE;
                            end
                        end
                        default: r_pc <= r_pc + 6'd1;
                    endcase
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_mac_done_only_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.mac_done |-> (r_state == ST_RUN && uw.op == hcd_pkg::OP_MAC))
        else $error("multiply completion outside a multiply step");

    a_idle_loop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_k == '0 && !r_bis))
        else $error("loop counter or damping phase left set in idle");

    a_bisect_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bis |-> (r_lo < r_a && r_a < r_hi))
        else $error("blend weight outside its bisection bounds");

endmodule

>>> test/homography_crop_damping_tb.sv
`timescale 1ns / 1ps

module homography_crop_damping_tb;

    typedef logic signed [127:0] w_t;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 3000;

    class crop_damping_board;
        hcd_pkg::t_out  expected_q[$];
        int             mismatches;
        longint         frame_w;
        longint         frame_h;
        longint         scale;
        longint         cx[4];
        longint         cy[4];

        function new();
            mismatches = 0;
            frame_w = 1920;
            frame_h = 1080;
            scale = 58982;
        endfunction

        function bit ratio_ok(w_t n, w_t d, longint lim);
            w_t l;
            l = lim;
            if (d == 0) return 0;
            if (d < 0) begin
                n = -n;
                d = -d;
            end
            if (n < 0) return 0;
            return (n - d * l) < 0;
        endfunction

        function w_t minor(longint m[9], int p, int q, int r, int s);
            w_t x, y;
            x = m[p] * m[q];
            y = m[r] * m[s];
            return x - y;
        endfunction

        function bit corners_fit(longint m[9]);
            w_t adj[9];
            w_t det, nx, ny, dd, x, y, m0, m1, m2;
            adj[0] = minor(m, 4, 8, 5, 7);
            adj[1] = minor(m, 2, 7, 1, 8);
            adj[2] = minor(m, 1, 5, 2, 4);
            adj[3] = minor(m, 5, 6, 3, 8);
            adj[4] = minor(m, 0, 8, 2, 6);
            adj[5] = minor(m, 2, 3, 0, 5);
            adj[6] = minor(m, 3, 7, 4, 6);
            adj[7] = minor(m, 1, 6, 0, 7);
            adj[8] = minor(m, 0, 4, 1, 3);
            m0 = m[0];
            m1 = m[1];
            m2 = m[2];
            det = adj[0] * m0 + adj[3] * m1 + adj[6] * m2;
            if (det == 0) return 0;
            for (int i = 0; i < 4; i++) begin
                x = cx[i];
                y = cy[i];
                nx = adj[0] * x + adj[1] * y + adj[2];
                ny = adj[3] * x + adj[4] * y + adj[5];
                dd = adj[6] * x + adj[7] * y + adj[8];
                if (!ratio_ok(nx, dd, frame_w)) return 0;
                if (!ratio_ok(ny, dd, frame_h)) return 0;
            end
            return 1;
        endfunction

        function void note(hcd_pkg::t_in d);
            longint h[9], b[9], wm, hm, sc, lo, hi, a, v;
            hcd_pkg::t_out r;
            h = '{d.h00, d.h01, d.h02, d.h10, d.h11, d.h12, d.h20, d.h21, d.h22};
            b = h;
            sc = (scale > 65536) ? 65536 : scale;
            wm = (frame_w * (65536 - sc)) >>> 17;
            hm = (frame_h * (65536 - sc)) >>> 17;
            cx = '{wm, frame_w - wm, frame_w - wm, wm};
            cy = '{hm, hm, frame_h - hm, frame_h - hm};
            r.was_modified = !corners_fit(h);
            if (r.was_modified) begin
                lo = 0;
                hi = 1 << hcd_pkg::BISECT_STEPS;
                for (int s = 0; s < hcd_pkg::BISECT_STEPS; s++) begin
                    a = (lo + hi) >>> 1;
                    for (int i = 0; i < 9; i++) begin
                        v = a * h[i] + (1 << (hcd_pkg::BISECT_STEPS - 1));
                        if (i % 4 == 0)
                            v += ((64'sd1 << hcd_pkg::BISECT_STEPS) - a)
                                 * (64'sd1 << hcd_pkg::FRAC_BITS);
                        v = v >>> hcd_pkg::BISECT_STEPS;
                        if (v > 64'sd2147483647) v = 64'sd2147483647;
                        if (v < -64'sd2147483648) v = -64'sd2147483648;
                        b[i] = v;
                    end
                    if (corners_fit(b)) lo = a;
                    else hi = a;
                end
            end
            r.out_00 = b[0]; r.out_01 = b[1]; r.out_02 = b[2];
            r.out_10 = b[3]; r.out_11 = b[4]; r.out_12 = b[5];
            r.out_20 = b[6]; r.out_21 = b[7]; r.out_22 = b[8];
            expected_q.push_back(r);
        endfunction

        function void check(hcd_pkg::t_out got);
            hcd_pkg::t_out e;
            logic [31:0] ev[10], gv[10];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            e = expected_q.pop_front();
            ev = '{e.out_00, e.out_01, e.out_02, e.out_10, e.out_11, e.out_12,
                   e.out_20, e.out_21, e.out_22, 32'(e.was_modified)};
            gv = '{got.out_00, got.out_01, got.out_02, got.out_10, got.out_11,
                   got.out_12, got.out_20, got.out_21, got.out_22, 32'(got.was_modified)};
            for (int i = 0; i < 10; i++) begin
                if (ev[i] !== gv[i]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("field %0d: expected %h, got %h", i, ev[i], gv[i]);
                end
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    hcd_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    hcd_pkg::t_out o_out_data;
    logic          i_cfg_valid;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index;
    logic [16:0]   i_cfg_data;

    crop_damping_board board;
    bit                idle_en;
    bit                hold_req;
    int                hold_cnt;
    int                quiet_cycles;

    homography_crop_damping u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) board.note(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) board.check(o_out_data);
    end

    always @(posedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= !(idle_en && $urandom_range(99) < 9);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(hcd_pkg::t_in d);
        if (idle_en && $urandom_range(99) < 9) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        case (idx)
            hcd_pkg::CFG_WIDTH:  board.frame_w = val & 17'h3fff;
            hcd_pkg::CFG_HEIGHT: board.frame_h = val & 17'h3fff;
            hcd_pkg::CFG_SCALE:  board.scale = val;
            default: ;
        endcase
    endtask

    task automatic set_frame(int w, int h, int s);
        drain();
        write_reg(hcd_pkg::CFG_WIDTH, 17'(w));
        write_reg(hcd_pkg::CFG_HEIGHT, 17'(h));
        write_reg(hcd_pkg::CFG_SCALE, 17'(s));
    endtask

    function automatic hcd_pkg::t_in from_list(longint m[9]);
        hcd_pkg::t_in d;
        d = '{32'(m[0]), 32'(m[1]), 32'(m[2]), 32'(m[3]), 32'(m[4]),
              32'(m[5]), 32'(m[6]), 32'(m[7]), 32'(m[8])};
        return d;
    endfunction

    function automatic hcd_pkg::t_in random_item();
        longint m[9];
        longint one;
        int kind;
        one = 1 << hcd_pkg::FRAC_BITS;
        kind = $urandom_range(99);
        if (kind < 20) begin
            for (int i = 0; i < 9; i++) m[i] = signed'($urandom);
        end else begin
            m[0] = one + $signed($urandom_range(0, 200000)) - 100000;
            m[4] = one + $signed($urandom_range(0, 200000)) - 100000;
            m[8] = (kind < 25) ? $signed($urandom_range(0, 2 * one)) : one;
            m[1] = $signed($urandom_range(0, 100000)) - 50000;
            m[3] = $signed($urandom_range(0, 100000)) - 50000;
            m[2] = ($signed($urandom_range(0, 400)) - 200) * one
                   + $signed($urandom_range(0, one - 1));
            m[5] = ($signed($urandom_range(0, 400)) - 200) * one
                   + $signed($urandom_range(0, one - 1));
            m[6] = $signed($urandom_range(0, 600)) - 300;
            m[7] = $signed($urandom_range(0, 600)) - 300;
        end
        return from_list(m);
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    initial begin
        longint one;
        longint dir[$][9];
        one = 1 << hcd_pkg::FRAC_BITS;
        board = new();
        idle_en = 0;
        hold_req = 0;
        hold_cnt = 0;
        quiet_cycles = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_out_ready = 0;
        i_cfg_valid = 0;
        i_cfg_index = hcd_pkg::CFG_WIDTH;
        i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        dir.push_back('{one, 0, 0, 0, one, 0, 0, 0, one});
        dir.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        dir.push_back('{2147483647, 2147483647, 2147483647, 2147483647, 2147483647,
                        2147483647, 2147483647, 2147483647, 2147483647});
        dir.push_back('{-2147483648, -2147483648, -2147483648, -2147483648, -2147483648,
                        -2147483648, -2147483648, -2147483648, -2147483648});
        dir.push_back('{2147483647, 0, 0, 0, 2147483647, 0, 0, 0, 2147483647});
        dir.push_back('{-2147483648, 0, 0, 0, 2147483647, 0, 0, 0, one});
        dir.push_back('{one, 0, 500 * one, 0, one, -300 * one, 0, 0, one});
        dir.push_back('{one, 0, 30 * one, 0, one, 20 * one, 0, 0, one});
        dir.push_back('{2 * one, 0, 0, 0, 2 * one, 0, 0, 0, one});
        dir.push_back('{one / 2, 0, 0, 0, one / 2, 0, 0, 0, one});
        dir.push_back('{one, one, 0, one, one, 0, 0, 0, one});
        dir.push_back('{one, 0, 0, 0, one, 0, 0, 0, 0});
        dir.push_back('{one, 0, 0, 0, one, 0, one / 1000, one / 1000, one});
        dir.push_back('{one, 30000, 0, -30000, one, 0, 0, 0, one});
        dir.push_back('{-one, 0, 0, 0, -one, 0, 0, 0, -one});
        dir.push_back('{one, 0, -one, 0, one, -one, 0, 0, one});
        foreach (dir[i]) send_item(from_list(dir[i]));

        idle_en = 1;
        random_run(40);
        idle_en = 0;
        random_run(30);
        idle_en = 1;
        hold_req = 1;
        random_run(10);
        drain();
        random_run(10);

        set_frame(8192, 8192, 65536);
        random_run(30);
        set_frame(1, 1, 0);
        send_item(from_list(dir[0]));
        random_run(20);
        set_frame(640, 480, 131071);
        random_run(30);
        set_frame(0, 0, 32768);
        send_item(from_list(dir[0]));
        random_run(8);
        set_frame(100, 50, 32768);
        send_item(from_list(dir[0]));
        send_item(from_list(dir[6]));
        random_run(30);
        set_frame(16383, 8192, 1);
        random_run(20);
        set_frame(1920, 1080, 58982);
        random_run(50);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
